/* hdl/three_of_six_frame_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the frame decoder module.
// ----------------------------------------------------------------------------
`ifndef THREE_OF_SIX_FRAME_DECODER_MACROS_SVH
`define THREE_OF_SIX_FRAME_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOSFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOSFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tosfd_pkg.sv */
// ----------------------------------------------------------------------------
// tosfd_pkg
// Types, constants and the symbol table of the 3-of-6 frame decoder.
// ----------------------------------------------------------------------------
package tosfd_pkg;

  // Largest number of decoded bytes kept per frame.
  localparam logic [8:0] MAX_OUTPUT = 9'd256;

  // Configuration register indexes.
  localparam logic CFG_START_BIT_OFFSET = 1'b0;
  localparam logic CFG_OUTPUT_LIMIT     = 1'b1;

  // Frame status codes.
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_INVALID   = 3'd1;
  localparam logic [2:0] STATUS_ODD       = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_EMPTY     = 3'd4;

  // 6-bit code word for each nibble.
  localparam logic [5:0] CODE_OF_NIBBLE [16] = '{
    6'h16, 6'h0D, 6'h0E, 6'h0B, 6'h1C, 6'h19, 6'h1A, 6'h13,
    6'h2C, 6'h25, 6'h26, 6'h23, 6'h34, 6'h31, 6'h32, 6'h29
  };

  typedef struct packed {
    logic [7:0] raw_byte;
    logic [3:0] valid_bit_count;
    logic       frame_last;
  } item_t;

  typedef struct packed {
    logic [2:0] start_bit_offset;
    logic [8:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic [4:0] pending_bits;
    logic [2:0] pending_count;
    logic [3:0] upper_nibble;
    logic       upper_held;
    logic [8:0] produced_count;
    logic       first_pending;
    logic       discarding;
    logic       full_stop;
  } state_t;

  localparam state_t STATE_RESET = '{
    pending_bits: 5'd0, pending_count: 3'd0, upper_nibble: 4'd0, upper_held: 1'b0,
    produced_count: 9'd0, first_pending: 1'b1, discarding: 1'b0, full_stop: 1'b0
  };

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic       byte_valid;
    logic       frame_done;
    logic [2:0] frame_status;
    logic [8:0] byte_total;
  } result_t;

  // Maps a code word to its nibble; bit 4 set means the code is not valid.
  function automatic logic [4:0] symbol_lookup(input logic [5:0] sym);
    logic [4:0] found;
    found = 5'h10;
    for (int k = 0; k < 16; k++) begin
      if (CODE_OF_NIBBLE[k] == sym) begin
        found = {1'b0, 4'(k)};
      end
    end
    return found;
  endfunction

endpackage

/* hdl/three_of_six_frame_decoder.sv */
// ----------------------------------------------------------------------------
// three_of_six_frame_decoder
// Turns frames of raw 3-of-6 coded radio bytes into decoded data bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one raw byte per item with its valid bit count and a flag
//   that marks the last byte of a frame. Output channel: at most one result
//   item per input item, carrying a decoded byte, the frame-done flag with a
//   status, and the byte count of the frame so far. Input items that neither
//   complete a byte nor close a frame give no result.
//   An accepted item is registered in the input register, decoded, and its
//   result is offered from the output register.
//   Throughput is one item per cycle unless a stall holds a result back; the
//   frame state is updated as each item leaves the input register, so items follow back to back.
//   When the receiver stalls, the result waits in the output register and the
//   input register holds its item only if it has a result to deliver; items
//   without a result keep flowing. Reset clears the frame state, empties both
//   registers and sets the start bit offset to zero and the output limit to
//   256. Configuration is written through cfg_write, cfg_index and cfg_data;
//   the user must write it only while no frame is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
`include "three_of_six_frame_decoder_macros.svh"

module three_of_six_frame_decoder import tosfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] raw_byte,
  input  logic [3:0] valid_bit_count,
  input  logic       frame_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] decoded_byte,
  output logic       byte_valid,
  output logic       frame_done,
  output logic [2:0] frame_status,
  output logic [8:0] byte_total
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  logic    s1_valid;
  item_t   s1_item;
  result_t step_result;
  logic    step_has_result;
  result_t out_result;
  logic    out_free;
  logic    s1_advance;

  tosfd_step u_step (
    .item       (s1_item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (step_result),
    .has_result (step_has_result)
  );

  // Flow control between the input register and the output register.
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && (out_free || !step_has_result);
  assign in_stall   = s1_valid && !s1_advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_bit_offset <= 3'd0;
      cfg.output_limit     <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_START_BIT_OFFSET: cfg.start_bit_offset <= cfg_data[2:0];
        CFG_OUTPUT_LIMIT:     cfg.output_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state: register valids and the frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_advance && step_has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (s1_advance) begin
        state <= state_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{raw_byte: raw_byte, valid_bit_count: valid_bit_count,
                   frame_last: frame_last};
    end
    if (s1_advance && step_has_result) begin
      out_result <= step_result;
    end
  end

  assign decoded_byte = out_result.decoded_byte;
  assign byte_valid   = out_result.byte_valid;
  assign frame_done   = out_result.frame_done;
  assign frame_status = out_result.frame_status;
  assign byte_total   = out_result.byte_total;

  // Checks on the decoder's own bookkeeping.
  `TOSFD_ASSERT_NOW(a_pending_short, clk, rst, 1'b1, state.pending_count <= 3'd5, "pending bits hold a whole symbol")
  `TOSFD_ASSERT_NOW(a_total_bound, clk, rst, out_valid, byte_total <= MAX_OUTPUT, "byte total above maximum")
  `TOSFD_ASSERT_NOW(a_status_done, clk, rst, out_valid && !frame_done, frame_status == STATUS_OK, "status without frame end")
  `TOSFD_ASSERT_NOW(a_idle_byte, clk, rst, out_valid && !byte_valid, decoded_byte == 8'd0, "stale byte without byte_valid")
  `TOSFD_ASSERT_NEXT(a_frame_clear, clk, rst, s1_advance && s1_item.frame_last, state.first_pending && (state.produced_count == 9'd0), "frame state not cleared after last byte")

endmodule

/* hdl/tosfd_step.sv */
// ----------------------------------------------------------------------------
// tosfd_step
// Decodes one raw byte against the frame state: bit gathering, up to two
// symbols, byte assembly and frame status.
// ----------------------------------------------------------------------------
module tosfd_step import tosfd_pkg::*; (
  input  item_t   item,
  input  cfg_t    cfg,
  input  state_t  state,
  output state_t  state_next,
  output result_t result,
  output logic    has_result
);

  logic [3:0]  n;
  logic [3:0]  skip;
  logic [3:0]  used;
  logic [7:0]  aligned;
  logic [8:0]  mask;
  logic [7:0]  bits;
  logic [12:0] acc;
  logic [3:0]  cnt;
  logic [3:0]  rem;
  logic [12:0] rem_mask;
  logic [8:0]  limit;
  logic [5:0]  sym [2];
  logic        take [2];
  logic [4:0]  look;
  logic        have_byte;
  logic [7:0]  byte_out;
  state_t      st;
  logic [2:0]  status;

  // Gather the valid bits of this byte onto the pending bits.
  always_comb begin
    n       = (item.valid_bit_count > 4'd8) ? 4'd8 : item.valid_bit_count;
    skip    = state.first_pending ? {1'b0, cfg.start_bit_offset} : 4'd0;
    used    = (n > skip) ? (n - skip) : 4'd0;
    aligned = item.raw_byte >> (4'd8 - n);
    mask    = (9'd1 << used) - 9'd1;
    bits    = aligned & mask[7:0];
    acc     = ({8'd0, state.pending_bits} << used) | {5'd0, bits};
    cnt     = {1'b0, state.pending_count} + used;
    take[0] = (cnt >= 4'd6);
    take[1] = (cnt >= 4'd12);
    sym[0]  = 6'(acc >> (cnt - 4'd6));
    sym[1]  = 6'(acc >> (cnt - 4'd12));
    rem     = take[1] ? (cnt - 4'd12) : (take[0] ? (cnt - 4'd6) : cnt);
    rem_mask = (13'd1 << rem) - 13'd1;
  end

  // Run the symbols in order through the nibble pairing.
  always_comb begin
    limit     = (cfg.output_limit > MAX_OUTPUT) ? MAX_OUTPUT : cfg.output_limit;
    st        = state;
    have_byte = 1'b0;
    byte_out  = 8'd0;
    look      = 5'd0;
    st.first_pending = 1'b0;
    st.pending_bits  = 5'(acc & rem_mask);
    st.pending_count = rem[2:0];
    for (int k = 0; k < 2; k++) begin
      look = symbol_lookup(sym[k]);
      if (take[k] && !st.discarding && !st.full_stop) begin
        if (look[4]) begin
          st.discarding = 1'b1;
        end else if (!st.upper_held) begin
          st.upper_nibble = look[3:0];
          st.upper_held   = 1'b1;
        end else if (st.produced_count >= limit) begin
          st.full_stop = 1'b1;
        end else begin
          byte_out          = {st.upper_nibble, look[3:0]};
          have_byte         = 1'b1;
          st.produced_count = st.produced_count + 9'd1;
          st.upper_held     = 1'b0;
        end
      end
    end
  end

  // Close the frame with a status on its last byte.
  always_comb begin
    status = STATUS_OK;
    if (item.frame_last) begin
      if (st.discarding) begin
        status = STATUS_INVALID;
      end else if (st.full_stop) begin
        status = STATUS_FULL;
      end else if (st.upper_held) begin
        status = STATUS_ODD;
      end else if (st.produced_count == 9'd0) begin
        status = STATUS_EMPTY;
      end
    end
    result.decoded_byte = byte_out;
    result.byte_valid   = have_byte;
    result.frame_done   = item.frame_last;
    result.frame_status = status;
    result.byte_total   = st.produced_count;
    has_result          = have_byte || item.frame_last;
    state_next          = item.frame_last ? STATE_RESET : st;
  end

endmodule
